// ----- design/sorted_letter_map_bsearch_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted letter map assertion macros
// Shared concurrent assertion forms for the sorted letter map block.
// ----------------------------------------------------------------------------
`ifndef SORTED_LETTER_MAP_BSEARCH_MACROS_SVH
`define SORTED_LETTER_MAP_BSEARCH_MACROS_SVH

// same-cycle implication, off during reset
`define SLMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SLMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/slmb_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted letter map package
// Field widths, request kinds and status codes of the sorted letter map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slmb_pkg;

  localparam int LetterW  = 8;
  localparam int NodeW    = 24;
  localparam int KindW    = 2;
  localparam int StatusW  = 2;
  localparam int InDataW  = 32;
  localparam int OutDataW = 32;
  localparam int OutUsedW = 1 + NodeW + StatusW;

  typedef enum logic [KindW-1:0] {
    KIND_FIND    = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_REPLACE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_ORDER     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ----- design/sorted_letter_map_bsearch.sv -----
// ----------------------------------------------------------------------------
// Sorted letter map with binary search
// Table of (letter, node) pairs in rising letter order; find, insert at the
// end, replace and clear, searched by a halving probe sequencer.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                  tuser
// s_axis   in   letter[7:0], node[31:8]             kind[1:0]
// m_axis   out  found[0], result_node[24:1],        -
//               status[26:25], zero pad [31:27]
//
// Insert and clear: accept, then the result state S_RESP.
// Find and replace: accept, one probe per cycle in S_CMP (at most
// clog2(MAX_ENTRIES)+1 probes; the rate is set by the single letter memory
// read port), then the result state S_RESP.
// One request in flight; s_axis_tready is low while it is worked on.
// A result waits in the output register; a stalled output holds only the
// next result, not the next accept. Reset empties the table, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_letter_map_bsearch #(
  parameter int MAX_ENTRIES = 256,
  parameter int NODE_BITS   = 24
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire  [slmb_pkg::InDataW-1:0]  s_axis_tdata_i,  // letter, node
  input  wire  [slmb_pkg::KindW-1:0]    s_axis_tuser_i,  // kind
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  output logic [slmb_pkg::OutDataW-1:0] m_axis_tdata_o   // found, result_node, status
);
  import slmb_pkg::*;

  localparam int CntW   = $clog2(MAX_ENTRIES + 1);
  localparam int IdxW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int StoreW = (NODE_BITS < NodeW) ? NODE_BITS : NodeW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     base_q, base_d;
  logic [CntW-1:0]     span_q, span_d;
  logic [CntW-1:0]     probe_q, addr_d;
  logic [LetterW-1:0]  key_q, key_d;
  logic [StoreW-1:0]   node_q, node_d;
  kind_e               kind_q, kind_d;
  logic [LetterW-1:0]  last_q, last_d;
  logic                res_found_q, res_found_d;
  logic                res_node_q, res_node_d;
  status_e             res_status_q, res_status_d;
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic [LetterW-1:0]  letter_mem [MAX_ENTRIES];
  logic [StoreW-1:0]   node_mem   [MAX_ENTRIES];
  logic [LetterW-1:0]  rd_letter_q;
  logic [StoreW-1:0]   rd_node_q;

  logic                s_acc;
  logic                letter_we;
  logic                node_we;
  logic [IdxW-1:0]     node_waddr;
  logic [StoreW-1:0]   node_wdata;
  logic                out_load;
  logic [LetterW-1:0]  in_letter;
  logic [StoreW-1:0]   in_node;
  logic [NodeW-1:0]    out_node;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign in_letter       = s_axis_tdata_i[LetterW-1:0];
  assign in_node         = s_axis_tdata_i[LetterW +: StoreW];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    span_d       = span_q;
    key_d        = key_q;
    node_d       = node_q;
    kind_d       = kind_q;
    last_d       = last_q;
    res_found_d  = res_found_q;
    res_node_d   = res_node_q;
    res_status_d = res_status_q;
    letter_we    = 1'b0;
    node_we      = 1'b0;
    node_waddr   = probe_q[IdxW-1:0];
    node_wdata   = node_q;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          key_d        = in_letter;
          node_d       = in_node;
          kind_d       = kind_e'(s_axis_tuser_i);
          res_found_d  = 1'b0;
          res_node_d   = 1'b0;
          res_status_d = ST_OK;
          state_d      = S_RESP;
          case (kind_e'(s_axis_tuser_i))
            KIND_FIND, KIND_REPLACE: begin
              base_d = '0;
              span_d = cnt_q;
              if (cnt_q == '0) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                state_d = S_CMP;
              end
            end
            KIND_INSERT: begin
              if (cnt_q >= CntW'(MAX_ENTRIES)) begin
                res_status_d = ST_FULL;
              end else if (cnt_q != '0 && in_letter <= last_q) begin
                res_status_d = ST_ORDER;
              end else begin
                letter_we  = 1'b1;
                node_we    = 1'b1;
                node_waddr = cnt_q[IdxW-1:0];
                node_wdata = in_node;
                last_d     = in_letter;
                cnt_d      = cnt_q + CntW'(1);
              end
            end
            KIND_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CMP: begin
        if (key_q == rd_letter_q) begin
          res_found_d = 1'b1;
          state_d     = S_RESP;
          if (kind_q == KIND_FIND) begin
            res_node_d = 1'b1;
          end else begin
            node_we = 1'b1;
          end
        end else begin
          if (key_q > rd_letter_q) begin
            base_d = probe_q + CntW'(1);
            span_d = (span_q - CntW'(1)) >> 1;
          end else begin
            span_d = span_q >> 1;
          end
          if (span_d == '0) begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign addr_d   = base_d + (span_d >> 1);
  assign out_node = res_node_q ? NodeW'(rd_node_q) : '0;

  always_comb begin
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = OutDataW'({res_status_q, out_node, res_found_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (letter_we) begin
      letter_mem[cnt_q[IdxW-1:0]] <= key_d;
    end
    rd_letter_q <= letter_mem[addr_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    rd_node_q <= node_mem[probe_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    span_q       <= span_d;
    probe_q      <= addr_d;
    key_q        <= key_d;
    node_q       <= node_d;
    kind_q       <= kind_d;
    last_q       <= last_d;
    res_found_q  <= res_found_d;
    res_node_q   <= res_node_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`include "sorted_letter_map_bsearch_macros.svh"

  `SLMB_ASSERT_NEXT(a_clear_empties,
    s_acc && s_axis_tuser_i == KIND_CLEAR,
    cnt_q == '0,
    "clear left entries")
  `SLMB_ASSERT_NOW(a_probe_window,
    state_q == S_CMP,
    span_q != '0 && base_q < cnt_q && span_q <= cnt_q - base_q,
    "probe window outside table")
  `SLMB_ASSERT_NOW(a_count_from_idle,
    cnt_q != $past(cnt_q),
    $past(state_q) == S_IDLE,
    "count changed mid request")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Sorted letter map testbench
// Drives find, insert, replace and clear requests with random gaps and output
// stalls. A directed table covers the edge cases, then random runs fill the
// table in rising letter order and probe it. Directed rows that carry an
// expected result are checked against it, the rest against a local table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import slmb_pkg::*;

  localparam int TableDepth = 256;
  localparam int RandItems  = 1700;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic        found;
    logic [23:0] node;
    status_e     status;
  } map_result_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  letter;
    logic [23:0] node;
    bit          typed;
    map_result_t want;
  } map_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;

  logic [7:0]  map_letter[TableDepth];
  logic [23:0] map_node[TableDepth];
  int          map_count = 0;

  map_result_t pending_results[$];
  int          fail_count = 0;
  int          sent_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;

  sorted_letter_map_bsearch dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // table model: halving search, append-only insert, replace in place, clear
  function automatic map_result_t predict_map(kind_e k, logic [7:0] l, logic [23:0] n);
    map_result_t r;
    int base;
    int span;
    int probe;
    int slot;
    r = '{found: 1'b0, node: 24'd0, status: ST_OK};
    slot = -1;
    if (k == KIND_FIND || k == KIND_REPLACE) begin
      base = 0;
      span = map_count;
      while (span != 0 && slot < 0) begin
        probe = base + (span >> 1);
        if (l == map_letter[probe]) begin
          slot = probe;
        end else begin
          if (l > map_letter[probe]) begin
            base = probe + 1;
            span = span - 1;
          end
          span = span >> 1;
        end
      end
      if (slot < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.found = 1'b1;
        if (k == KIND_FIND) r.node = map_node[slot];
        else map_node[slot] = n;
      end
    end else if (k == KIND_INSERT) begin
      if (map_count >= TableDepth) begin
        r.status = ST_FULL;
      end else if (map_count != 0 && l <= map_letter[map_count-1]) begin
        r.status = ST_ORDER;
      end else begin
        map_letter[map_count] = l;
        map_node[map_count] = n;
        map_count++;
      end
    end else begin
      map_count = 0;
    end
    return r;
  endfunction

  task automatic send_request(input kind_e k, input logic [7:0] l, input logic [23:0] n,
                              input bit typed, input map_result_t want);
    map_result_t pred;
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata  = {n, l};
    s_tuser  = k;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_map(k, l, n);
    pending_results.push_back(typed ? want : pred);
    sent_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // output side: random stalls, sampled on the rising edge
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    map_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %0h",
                 $realtime, m_axis_tdata_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("found", 32'(exp_r.found), 32'(m_axis_tdata_o[0]));
        compare_field("result_node", 32'(exp_r.node), 32'(m_axis_tdata_o[24:1]));
        compare_field("status", 32'(exp_r.status), 32'(m_axis_tdata_o[26:25]));
        compare_field("pad", 32'd0, 32'(m_axis_tdata_o[31:27]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[sorted_letter_map_bsearch] ERROR");
      $finish;
    end
  end

  initial begin
    map_row_t    rows[$];
    map_result_t none;
    int          rand_base;
    int          fills;
    int          choice;
    int          n_ins;
    int          n_look;
    int          last;
    int          nxt;
    int          step;
    logic [7:0]  l;
    kind_e       k;

    none = '{found: 1'b0, node: 24'd0, status: ST_OK};
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = KIND_FIND;

    rows = '{
      '{KIND_FIND,    8'h61, 24'h000000, 1, '{1'b0, 24'h000000, ST_NOT_FOUND}},
      '{KIND_REPLACE, 8'h00, 24'hffffff, 1, '{1'b0, 24'h000000, ST_NOT_FOUND}},
      '{KIND_INSERT,  8'h00, 24'h000000, 1, '{1'b0, 24'h000000, ST_OK}},
      '{KIND_INSERT,  8'h00, 24'hffffff, 1, '{1'b0, 24'h000000, ST_ORDER}},
      '{KIND_INSERT,  8'h10, 24'hffffff, 1, '{1'b0, 24'h000000, ST_OK}},
      '{KIND_INSERT,  8'h08, 24'h000001, 1, '{1'b0, 24'h000000, ST_ORDER}},
      '{KIND_INSERT,  8'h80, 24'h5a5a5a, 1, '{1'b0, 24'h000000, ST_OK}},
      '{KIND_FIND,    8'h00, 24'hffffff, 1, '{1'b1, 24'h000000, ST_OK}},
      '{KIND_FIND,    8'h10, 24'h000000, 1, '{1'b1, 24'hffffff, ST_OK}},
      '{KIND_FIND,    8'h80, 24'h000000, 0, none},
      '{KIND_FIND,    8'h40, 24'h000000, 1, '{1'b0, 24'h000000, ST_NOT_FOUND}},
      '{KIND_FIND,    8'hff, 24'h000000, 1, '{1'b0, 24'h000000, ST_NOT_FOUND}},
      '{KIND_REPLACE, 8'h10, 24'h123456, 1, '{1'b1, 24'h000000, ST_OK}},
      '{KIND_FIND,    8'h10, 24'h000000, 1, '{1'b1, 24'h123456, ST_OK}},
      '{KIND_REPLACE, 8'h20, 24'h654321, 1, '{1'b0, 24'h000000, ST_NOT_FOUND}},
      '{KIND_INSERT,  8'hff, 24'h000001, 1, '{1'b0, 24'h000000, ST_OK}},
      '{KIND_FIND,    8'hff, 24'h000000, 1, '{1'b1, 24'h000001, ST_OK}},
      '{KIND_INSERT,  8'hff, 24'h000002, 1, '{1'b0, 24'h000000, ST_ORDER}},
      '{KIND_CLEAR,   8'hff, 24'hffffff, 1, '{1'b0, 24'h000000, ST_OK}},
      '{KIND_FIND,    8'h10, 24'h000000, 1, '{1'b0, 24'h000000, ST_NOT_FOUND}},
      '{KIND_INSERT,  8'hff, 24'habcdef, 1, '{1'b0, 24'h000000, ST_OK}},
      '{KIND_FIND,    8'hff, 24'h000000, 0, none},
      '{KIND_FIND,    8'h00, 24'h000000, 0, none},
      '{KIND_CLEAR,   8'h00, 24'h000000, 1, '{1'b0, 24'h000000, ST_OK}}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_request(rows[i].kind, rows[i].letter, rows[i].node,
                                   rows[i].typed, rows[i].want);

    rand_base = sent_count;
    fills = 0;
    while (sent_count - rand_base < RandItems) begin
      calm = ($urandom_range(0, 9) == 0);
      if (fills < 2 && sent_count - rand_base >= 500 + fills * 700) choice = 99;
      else choice = $urandom_range(0, 9);

      if (choice == 99) begin
        // fill every slot, then hit the full table
        send_request(KIND_CLEAR, 8'($urandom), 24'($urandom), 0, none);
        for (int i = 0; i < TableDepth; i++)
          send_request(KIND_INSERT, 8'(i), 24'($urandom), 0, none);
        repeat (4) send_request(KIND_INSERT, 8'($urandom), 24'($urandom), 0, none);
        repeat (20) begin
          k = ($urandom_range(0, 1) == 0) ? KIND_FIND : KIND_REPLACE;
          send_request(k, 8'($urandom), 24'($urandom), 0, none);
        end
        fills++;
      end else if (choice < 8) begin
        if ($urandom_range(0, 99) < 80)
          send_request(KIND_CLEAR, 8'($urandom), 24'($urandom), 0, none);
        n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 20);
        step = $urandom_range(0, 30);
        repeat (n_ins) begin
          last = (map_count > 0) ? int'(map_letter[map_count-1]) : -1;
          if ($urandom_range(0, 99) < 90) begin
            nxt = last + 1 + $urandom_range(0, step);
            if (nxt > 255) nxt = 255;
          end else begin
            nxt = $urandom_range(0, 255);
          end
          send_request(KIND_INSERT, 8'(nxt), 24'($urandom), 0, none);
        end
        n_look = $urandom_range(2, 25);
        repeat (n_look) begin
          if (map_count > 0 && $urandom_range(0, 99) < 75)
            l = map_letter[$urandom_range(0, map_count - 1)];
          else
            l = 8'($urandom);
          k = ($urandom_range(0, 99) < 65) ? KIND_FIND : KIND_REPLACE;
          send_request(k, l, 24'($urandom), 0, none);
        end
      end else begin
        repeat ($urandom_range(1, 8))
          send_request(kind_e'($urandom_range(0, 3)), 8'($urandom), 24'($urandom), 0, none);
      end
    end

    @(negedge clk_i);
    s_tvalid = 1'b0;
    calm = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[sorted_letter_map_bsearch] OK");
    end else begin
      $display("[sorted_letter_map_bsearch] ERROR");
    end
    $finish;
  end

endmodule
